// ===== rtl/frim_pkg.sv =====
// Shared definitions for the four-register integer machine.
// Opcodes, stream word layout, default sizes and the controller/datapath
// command and status structs. No dependencies.
package frim_pkg;

  // Default sizes handed to the top-level parameters
  localparam int NUM_REGS_DEF   = 4;
  localparam int DATA_WIDTH_DEF = 32;

  // Input word: req_type[2:0], dest_reg[4:3], src_reg[6:5], immediate[38:7], pad[39]
  localparam int IN_TDATA_W = 40;
  localparam int IMM_W      = 32;

  // Request codes
  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_MOVE = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;
  localparam logic [2:0] OP_OUT  = 3'd6;

  // Result kinds carried on tuser
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_DIVERR = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // latch the incoming word
    logic rd;        // read both operands from the register file
    logic start;     // load the shift/add unit
    logic step;      // one multiply or divide iteration
    logic wr;        // write the result to the destination register
    logic out_ld;    // load the output register
    logic out_err;   // with out_ld: load a divide-by-zero error
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [2:0] op;       // latched request code
    logic       div_zero; // source operand is zero
    logic       last;     // final iteration
    logic       out_free; // output register can take a word this cycle
  } sts_t;

endpackage

// ===== rtl/frim_ctrl.sv =====
// Sequencing controller for the four-register integer machine.
// Drives the datapath through frim_pkg::cmd_t and reads frim_pkg::sts_t.
// Depends on frim_pkg.
module frim_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  frim_pkg::sts_t  sts_i,
  output frim_pkg::cmd_t  cmd_o
);
  import frim_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_ITER = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts_i.op)
          OP_LOAD, OP_MOVE, OP_ADD, OP_SUB: begin
            cmd_o.wr = 1'b1;
            state_d  = S_IDLE;
          end
          OP_MUL: begin
            cmd_o.start = 1'b1;
            state_d     = S_ITER;
          end
          OP_DIV: begin
            if (sts_i.div_zero) begin
              // error word, wait for room in the output register
              if (sts_i.out_free) begin
                cmd_o.out_ld  = 1'b1;
                cmd_o.out_err = 1'b1;
                state_d       = S_IDLE;
              end
            end else begin
              cmd_o.start = 1'b1;
              state_d     = S_ITER;
            end
          end
          OP_OUT: begin
            if (sts_i.out_free) begin
              cmd_o.out_ld = 1'b1;
              state_d      = S_IDLE;
            end
          end
          default: begin
            // unused code: no effect
            state_d = S_IDLE;
          end
        endcase
      end
      S_ITER: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.wr = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/frim_dp.sv =====
// Datapath of the four-register integer machine: instruction latch,
// register file with valid bits, shift/add multiply-divide unit, output register.
// Depends on frim_pkg.
module frim_dp #(
  parameter int NUM_REGS   = frim_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = frim_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [frim_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  frim_pkg::cmd_t                      cmd_i,
  output frim_pkg::sts_t                      sts_o,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_tdata_o,
  output logic                                m_tuser_o
);
  import frim_pkg::*;

  localparam int IdxW = $clog2(NUM_REGS);
  localparam int CntW = $clog2(DATA_WIDTH);
  localparam int OutW = ((DATA_WIDTH+7)/8)*8;

  // Register index wraps modulo NUM_REGS; a 2-bit field is below 2*NUM_REGS
  function automatic logic [IdxW-1:0] wrap_idx(input logic [1:0] field);
    logic [4:0] f;
    f = {3'b000, field};
    if (f >= 5'(NUM_REGS)) begin
      f = f - 5'(NUM_REGS);
    end
    return f[IdxW-1:0];
  endfunction

  // Instruction latch
  logic [2:0]               op_q;
  logic [IdxW-1:0]          dst_q, src_q;
  logic signed [IMM_W-1:0]  imm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= s_tdata_i[2:0];
      dst_q <= wrap_idx(s_tdata_i[4:3]);
      src_q <= wrap_idx(s_tdata_i[6:5]);
      imm_q <= s_tdata_i[38:7];
    end
  end

  // Register file: one write port, two registered read ports
  logic [DATA_WIDTH-1:0] rf_mem [NUM_REGS];
  logic [DATA_WIDTH-1:0] rda_q, rdb_q;
  logic [NUM_REGS-1:0]   vld_q;
  logic                  vlda_q, vldb_q;
  logic [DATA_WIDTH-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      rf_mem[dst_q] <= wr_data;
    end
    if (cmd_i.rd) begin
      rda_q <= rf_mem[dst_q];
      rdb_q <= rf_mem[src_q];
    end
  end

  // Valid bits: a never-written register reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vlda_q <= 1'b0;
      vldb_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        vld_q[dst_q] <= 1'b1;
      end
      if (cmd_i.rd) begin
        vlda_q <= vld_q[dst_q];
        vldb_q <= vld_q[src_q];
      end
    end
  end

  logic [DATA_WIDTH-1:0] opa, opb;
  assign opa = vlda_q ? rda_q : '0;
  assign opb = vldb_q ? rdb_q : '0;

  // Shift/add unit: multiply (low half) or restoring divide on magnitudes
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] x_q, x_d;
  logic [DATA_WIDTH-1:0] y_q, y_d;
  logic                  neg_q, neg_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH:0]   rem_sh, rem_diff;
  logic                  is_div;

  assign is_div   = (op_q == OP_DIV);
  assign rem_sh   = {acc_q, x_q[DATA_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, y_q};

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    y_d   = y_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      acc_d = '0;
      cnt_d = CntW'(DATA_WIDTH - 1);
      if (is_div) begin
        x_d   = opa[DATA_WIDTH-1] ? (~opa + 1'b1) : opa;
        y_d   = opb[DATA_WIDTH-1] ? (~opb + 1'b1) : opb;
        neg_d = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
      end else begin
        x_d   = opa;
        y_d   = opb;
        neg_d = 1'b0;
      end
    end else if (cmd_i.step) begin
      cnt_d = cnt_q - 1'b1;
      if (is_div) begin
        // quotient bits shift into x from the right
        if (!rem_diff[DATA_WIDTH]) begin
          acc_d = rem_diff[DATA_WIDTH-1:0];
          x_d   = {x_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[DATA_WIDTH-1:0];
          x_d   = {x_q[DATA_WIDTH-2:0], 1'b0};
        end
      end else begin
        if (x_q[0]) begin
          acc_d = acc_q + y_q;
        end
        x_d = x_q >> 1;
        y_d = y_q << 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  // Write-back selection
  always_comb begin
    unique case (op_q)
      OP_LOAD: wr_data = DATA_WIDTH'(imm_q);
      OP_MOVE: wr_data = opb;
      OP_ADD:  wr_data = opa + opb;
      OP_SUB:  wr_data = opa - opb;
      OP_MUL:  wr_data = acc_q;
      OP_DIV:  wr_data = neg_q ? (~x_q + 1'b1) : x_q;
      default: wr_data = opb;
    endcase
  end

  // Output register, free again in the cycle the word is taken
  logic                  out_vld_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic                  out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_data_q <= cmd_i.out_err ? '0 : opa;
      out_kind_q <= cmd_i.out_err ? KIND_DIVERR : KIND_VALUE;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = OutW'(out_data_q);
  assign m_tuser_o  = out_kind_q;

  // Status to the controller
  assign sts_o.op       = op_q;
  assign sts_o.div_zero = (opb == '0);
  assign sts_o.last     = (cnt_q == '0);
  assign sts_o.out_free = !out_vld_q || m_tready_i;

endmodule

// ===== rtl/four_register_integer_machine_top.sv =====
// Top level of the four-register integer machine.
// Joins frim_ctrl and frim_dp; depends on frim_pkg.
//
//  channel | dir | handshake          | word contents (low bit up)
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | req_type, dest_reg, src_reg, immediate, pad
//  m_      | out | m_tvalid/m_tready  | tdata: out_value, pad; tuser: result_kind
//
//  One instruction is handled at a time. Load, move, add, subtract, output and
//  divide-by-zero pass through the read and execute states before the next accept.
//  Multiply and divide also iterate in the one-bit-per-cycle shift/add unit in the
//  datapath, then pass through a write-back state.
//  A result word waits in the output register; a further output stalls only
//  while that register is full and m_tready_i is low.
//  Reset clears the registers to zero at once through per-register valid bits.
module four_register_integer_machine_top #(
  parameter int NUM_REGS   = frim_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = frim_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // req_type[2:0], dest_reg[4:3], src_reg[6:5], immediate[38:7], zero pad[39]
  input  logic [frim_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // out_value[DATA_WIDTH-1:0], zero pad up to a whole byte
  output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata_o,
  // result_kind[0]
  output logic                              m_tuser_o
);
  import frim_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  frim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Register file and arithmetic
  frim_dp #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

// ===== rtl/frim_chk.sv =====
// Port-level checks for the four-register integer machine, bound to the top.
// Depends on frim_pkg and four_register_integer_machine_top.
module frim_chk #(
  parameter int DATA_WIDTH = frim_pkg::DATA_WIDTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid_i,
  input logic                            s_tready_i,
  input logic                            m_tvalid_i,
  input logic                            m_tready_i,
  input logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata_i,
  input logic                            m_tuser_i
);
  import frim_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("result word changed while stalled");

  // An error word carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == KIND_DIVERR) |-> m_tdata_i == '0)
    else $error("error word with nonzero value");

  // One instruction at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input accepted while busy");

  // A new result appears only as an instruction finishes
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_i) |-> $past(!s_tready_i))
    else $error("result word without an instruction in flight");

endmodule

bind four_register_integer_machine_top frim_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_frim_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_i (s_tready_o),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tuser_i  (m_tuser_o)
);
